// File: hdl/paid_relay_session_timer_defines.svh
// ----------------------------------------------------------------------------
// Paid relay session timer assertion macros
// Concurrent assertion wrappers used by the top-level file to check its logic.
// ----------------------------------------------------------------------------
`ifndef PAID_RELAY_SESSION_TIMER_DEFINES_SVH
`define PAID_RELAY_SESSION_TIMER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside of reset.
`define PRST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define PRST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PRST_ASSERT(label, prop, msg)
`define PRST_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: hdl/prst_pkg.sv
// ----------------------------------------------------------------------------
// Paid relay session timer package
// Shared widths, register reset values, event codes and inter-module types.
// ----------------------------------------------------------------------------
package prst_pkg;

   localparam int NUM_RELAYS = 8;
   // Only eight buttons exist; further relay slots never see a press.
   localparam int NUM_LANES  = (NUM_RELAYS < 8) ? NUM_RELAYS : 8;

   localparam int BTN_W      = 8;
   localparam int RELAY_W    = 3;
   localparam int DRIVE_W    = 8;
   localparam int SEC_W      = 10;
   localparam int DUR_W      = 20;
   localparam int PAUSE_W    = 12;
   localparam int REPORT_W   = 11;
   localparam int SINCE_W    = 11;
   localparam int GAP_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [REPORT_W-1:0] REPORT_PERIOD_MS = 11'd1000;

   localparam logic [15:0] BASE_TIME_RST     = 16'd30000;
   localparam logic [11:0] EXTRA_TIME_RST    = 12'd3000;
   localparam logic [9:0]  DEBOUNCE_GAP_RST  = 10'd500;
   localparam logic [11:0] PAUSE_LOCKOUT_RST = 12'd3000;
   localparam logic [11:0] RESUME_WAIT_RST   = 12'd2000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_TIME     = 3'd0,
      CSR_EXTRA_TIME    = 3'd1,
      CSR_DEBOUNCE_GAP  = 3'd2,
      CSR_PAUSE_LOCKOUT = 3'd3,
      CSR_RESUME_WAIT   = 3'd4
   } prst_csr_type;

   typedef enum logic [3:0] {
      EV_PAID          = 4'd0,
      EV_NOT_PAID      = 4'd1,
      EV_STARTED       = 4'd2,
      EV_PAUSE_DENIED  = 4'd3,
      EV_PAUSED        = 4'd4,
      EV_RESUME_DENIED = 4'd5,
      EV_RESUMED       = 4'd6,
      EV_BUSY          = 4'd7,
      EV_COUNTDOWN     = 4'd8,
      EV_STOPPED       = 4'd9
   } prst_event_type;

   typedef struct packed {
      logic [15:0] base_time;
      logic [11:0] extra_time;
      logic [GAP_W-1:0] debounce_gap;
      logic [11:0] pause_lockout;
      logic [11:0] resume_wait;
   } prst_cfg_type;

   // One tick as handed to the session sequencer.
   typedef struct packed {
      logic pay_valid;
      logic pay_has_extra;
      logic [7:0] pay_extra_impulses;
      logic [NUM_LANES-1:0] hits;
   } prst_job_type;

   // One sequencer output slot: an event record, a tick end mark, or both.
   typedef struct packed {
      logic valid;
      logic has_rec;
      logic tick_end;
      prst_event_type code;
      logic [RELAY_W-1:0] relay;
      logic [DUR_W-1:0] ms;
      logic [DRIVE_W-1:0] drive;
   } prst_rec_type;

endpackage

// File: hdl/prst_channels.sv
// ----------------------------------------------------------------------------
// Paid relay session timer channels
// Valid/ready interfaces for the tick input and the event record output.
// ----------------------------------------------------------------------------
interface prst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] button_levels;
   logic       pay_valid;
   logic       pay_has_extra;
   logic [7:0] pay_extra_impulses;

   modport source (output valid, button_levels, pay_valid, pay_has_extra,
                   pay_extra_impulses, input ready);
   modport sink (input valid, button_levels, pay_valid, pay_has_extra,
                 pay_extra_impulses, output ready);
endinterface

interface prst_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] event_code;
   logic [2:0] relay_index;
   logic [9:0] seconds_value;
   logic [7:0] relay_drive;
   logic       last_of_tick;

   modport source (output valid, event_code, relay_index, seconds_value,
                   relay_drive, last_of_tick, input ready);
   modport sink (input valid, event_code, relay_index, seconds_value,
                 relay_drive, last_of_tick, output ready);
endinterface

// File: hdl/prst_lane.sv
// ----------------------------------------------------------------------------
// Button debounce lane
// Tracks one button's hold flag and time since its last accepted press.
// ----------------------------------------------------------------------------
module prst_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick,
   input  logic                        pressed,
   input  logic [prst_pkg::GAP_W-1:0]  gap,
   output logic                        hit
);
   import prst_pkg::*;

   logic               held_ff, held_in;
   logic [SINCE_W-1:0] since_ff, since_in;
   logic [SINCE_W-1:0] since_inc;

   assign since_inc = (since_ff == '1) ? since_ff : since_ff + SINCE_W'(1);
   assign hit = tick && pressed && !held_ff && (since_inc > SINCE_W'(gap));

   always_comb begin
      held_in  = held_ff;
      since_in = since_ff;
      if (tick) begin
         since_in = hit ? '0 : since_inc;
         // A press that misses the gap leaves the hold flag clear.
         held_in  = pressed ? (held_ff || hit) : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         since_ff <= '0;
      end else begin
         held_ff  <= held_in;
         since_ff <= since_in;
      end
   end

endmodule

// File: hdl/prst_core.sv
// ----------------------------------------------------------------------------
// Session sequencer
// Advances the session timers once per tick, then walks the payment, the
// accepted presses in button order and timer, one event per rec_ready cycle.
// ----------------------------------------------------------------------------
module prst_core (
   input  logic                    clock,
   input  logic                    reset,
   input  prst_pkg::prst_cfg_type  cfg,
   input  logic                    job_valid,
   input  prst_pkg::prst_job_type  job,
   output logic                    job_ready,
   output prst_pkg::prst_rec_type  rec,
   input  logic                    rec_ready
);
   import prst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAY,
      S_BTN,
      S_TIMER,
      S_STOP
   } state_type;

   state_type            state_ff, state_in;
   logic                 start_en_ff, start_en_in;
   logic                 running_ff, running_in;
   logic                 paused_ff, paused_in;
   logic [RELAY_W-1:0]   active_ff, active_in;
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic [DUR_W-1:0]     run_el_ff, run_el_in;
   logic [PAUSE_W-1:0]   pause_el_ff, pause_el_in;
   logic [REPORT_W-1:0]  report_el_ff, report_el_in;
   logic                 has_extra_ff, has_extra_in;
   logic [7:0]           imp_ff, imp_in;
   logic [NUM_LANES-1:0] mask_ff, mask_in;

   logic [DUR_W-1:0]     rem;
   logic [DUR_W-1:0]     prod;
   logic [DUR_W:0]       dur_sum;
   logic [DUR_W-1:0]     dur_pay;
   logic [DUR_W-1:0]     dur_left;
   logic [RELAY_W-1:0]   btn_sel;
   logic [NUM_LANES-1:0] mask_low;
   logic [NUM_LANES-1:0] mask_rest;

   assign rem      = (dur_ff > run_el_ff) ? dur_ff - run_el_ff : '0;
   assign prod     = imp_ff * cfg.extra_time;
   assign dur_sum  = (DUR_W+1)'(cfg.base_time) + (has_extra_ff ? {1'b0, prod} : '0);
   assign dur_pay  = dur_sum[DUR_W] ? '1 : dur_sum[DUR_W-1:0];
   assign dur_left = rem;
   assign mask_low  = mask_ff & (~mask_ff + NUM_LANES'(1));
   assign mask_rest = mask_ff & ~mask_low;

   always_comb begin
      btn_sel = '0;
      for (int i = NUM_LANES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            btn_sel = RELAY_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      start_en_in  = start_en_ff;
      running_in   = running_ff;
      paused_in    = paused_ff;
      active_in    = active_ff;
      dur_in       = dur_ff;
      run_el_in    = run_el_ff;
      pause_el_in  = pause_el_ff;
      report_el_in = report_el_ff;
      has_extra_in = has_extra_ff;
      imp_in       = imp_ff;
      mask_in      = mask_ff;
      rec          = '0;
      job_ready    = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               run_el_in    = (run_el_ff == '1) ? run_el_ff : run_el_ff + DUR_W'(1);
               pause_el_in  = (pause_el_ff == '1) ? pause_el_ff
                                                  : pause_el_ff + PAUSE_W'(1);
               report_el_in = (report_el_ff == '1) ? report_el_ff
                                                   : report_el_ff + REPORT_W'(1);
               has_extra_in = job.pay_has_extra;
               imp_in       = job.pay_extra_impulses;
               mask_in      = job.hits;
               if (job.pay_valid) begin
                  state_in = S_PAY;
               end else if (|job.hits) begin
                  state_in = S_BTN;
               end else begin
                  state_in = S_TIMER;
               end
            end
         end
         S_PAY: begin
            rec.valid   = 1'b1;
            rec.has_rec = 1'b1;
            rec.code    = EV_PAID;
            rec.ms      = dur_pay;
            dur_in      = dur_pay;
            start_en_in = 1'b1;
            state_in    = (|mask_ff) ? S_BTN : S_TIMER;
         end
         S_BTN: begin
            rec.valid   = 1'b1;
            rec.has_rec = 1'b1;
            mask_in     = mask_rest;
            state_in    = (|mask_rest) ? S_BTN : S_TIMER;
            if (!start_en_ff) begin
               rec.code  = EV_NOT_PAID;
               rec.relay = btn_sel;
            end else if (running_ff || paused_ff) begin
               rec.relay = active_ff;
               if (active_ff != btn_sel) begin
                  rec.code = EV_BUSY;
               end else if (!paused_ff) begin
                  if (run_el_ff < DUR_W'(cfg.pause_lockout)) begin
                     rec.code = EV_PAUSE_DENIED;
                  end else begin
                     rec.code    = EV_PAUSED;
                     rec.ms      = dur_left;
                     dur_in      = dur_left;
                     pause_el_in = '0;
                     paused_in   = 1'b1;
                  end
               end else begin
                  if (pause_el_ff < cfg.resume_wait) begin
                     rec.code = EV_RESUME_DENIED;
                  end else begin
                     rec.code     = EV_RESUMED;
                     rec.ms       = dur_ff;
                     paused_in    = 1'b0;
                     run_el_in    = '0;
                     report_el_in = '0;
                  end
               end
            end else begin
               rec.code     = EV_STARTED;
               rec.relay    = btn_sel;
               rec.ms       = dur_ff;
               active_in    = btn_sel;
               running_in   = 1'b1;
               paused_in    = 1'b0;
               run_el_in    = '0;
               report_el_in = '0;
            end
         end
         S_TIMER: begin
            rec.valid    = 1'b1;
            rec.tick_end = 1'b1;
            state_in     = S_IDLE;
            if (running_ff && !paused_ff) begin
               if (report_el_ff >= REPORT_PERIOD_MS) begin
                  rec.has_rec  = 1'b1;
                  rec.code     = EV_COUNTDOWN;
                  rec.relay    = active_ff;
                  rec.ms       = rem;
                  report_el_in = '0;
                  // The stop record of the same tick follows in its own cycle.
                  if (rem == '0) begin
                     rec.tick_end = 1'b0;
                     state_in     = S_STOP;
                  end
               end else if (rem == '0) begin
                  rec.has_rec = 1'b1;
                  rec.code    = EV_STOPPED;
                  rec.relay   = active_ff;
                  running_in  = 1'b0;
                  paused_in   = 1'b0;
                  active_in   = '0;
                  start_en_in = 1'b0;
               end
            end
         end
         S_STOP: begin
            rec.valid    = 1'b1;
            rec.has_rec  = 1'b1;
            rec.tick_end = 1'b1;
            rec.code     = EV_STOPPED;
            rec.relay    = active_ff;
            running_in   = 1'b0;
            paused_in    = 1'b0;
            active_in    = '0;
            start_en_in  = 1'b0;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The record carries the relay outputs as they stand after the event.
      rec.drive = (running_in && !paused_in) ? (DRIVE_W'(1) << active_in) : '0;

      if (rec.valid && !rec_ready) begin
         state_in     = state_ff;
         start_en_in  = start_en_ff;
         running_in   = running_ff;
         paused_in    = paused_ff;
         active_in    = active_ff;
         dur_in       = dur_ff;
         run_el_in    = run_el_ff;
         pause_el_in  = pause_el_ff;
         report_el_in = report_el_ff;
         mask_in      = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_en_ff  <= 1'b0;
         running_ff   <= 1'b0;
         paused_ff    <= 1'b0;
         active_ff    <= '0;
         dur_ff       <= '0;
         run_el_ff    <= '0;
         pause_el_ff  <= '0;
         report_el_ff <= '0;
         mask_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         start_en_ff  <= start_en_in;
         running_ff   <= running_in;
         paused_ff    <= paused_in;
         active_ff    <= active_in;
         dur_ff       <= dur_in;
         run_el_ff    <= run_el_in;
         pause_el_ff  <= pause_el_in;
         report_el_ff <= report_el_in;
         mask_ff      <= mask_in;
      end
      has_extra_ff <= has_extra_in;
      imp_ff       <= imp_in;
   end

endmodule

// File: hdl/prst_merge.sv
// ----------------------------------------------------------------------------
// Event record output stage
// Holds back one record until the next one or the tick end shows whether it
// closes the tick, converts milliseconds to seconds and drives the output.
// ----------------------------------------------------------------------------
module prst_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  prst_pkg::prst_rec_type rec,
   output logic                   rec_ready,
   prst_rsp_if.source             rsp_chan
);
   import prst_pkg::*;

   // 1000 = 8 * 125: drop three bits, then divide by 125 with a reciprocal
   // that is exact for every 17-bit quotient input.
   localparam int              SECS_SHIFT = 24;
   localparam int              PROD_W     = 35;
   localparam logic [PROD_W-1:0] SECS_RECIP = 35'd134218;
   localparam int              QUO_W      = 11;

   function automatic logic [SEC_W-1:0] ms_to_secs(input logic [DUR_W-1:0] ms);
      logic [PROD_W-1:0] p;
      logic [QUO_W-1:0]  q;
      p = PROD_W'(ms[DUR_W-1:3]) * SECS_RECIP;
      q = p[SECS_SHIFT +: QUO_W];
      return (q > QUO_W'(1023)) ? '1 : q[SEC_W-1:0];
   endfunction

   logic                 pend_v_ff, pend_v_in;
   logic                 pend_last_ff, pend_last_in;
   prst_event_type       pend_code_ff, pend_code_in;
   logic [RELAY_W-1:0]   pend_relay_ff, pend_relay_in;
   logic [DUR_W-1:0]     pend_ms_ff, pend_ms_in;
   logic [DRIVE_W-1:0]   pend_drive_ff, pend_drive_in;

   logic                 out_v_ff, out_v_in;
   prst_event_type       out_code_ff, out_code_in;
   logic [RELAY_W-1:0]   out_relay_ff, out_relay_in;
   logic [SEC_W-1:0]     out_secs_ff, out_secs_in;
   logic [DRIVE_W-1:0]   out_drive_ff, out_drive_in;
   logic                 out_last_ff, out_last_in;

   logic in_fire;
   logic out_free;
   logic push_out;

   assign out_free  = !out_v_ff || rsp_chan.ready;
   assign rec_ready = !pend_v_ff || out_free;
   assign in_fire   = rec.valid && rec_ready;
   // The held record leaves once its successor or the tick end is known.
   assign push_out  = pend_v_ff && out_free && (pend_last_ff || in_fire);

   always_comb begin
      pend_v_in     = pend_v_ff;
      pend_last_in  = pend_last_ff;
      pend_code_in  = pend_code_ff;
      pend_relay_in = pend_relay_ff;
      pend_ms_in    = pend_ms_ff;
      pend_drive_in = pend_drive_ff;
      out_v_in      = out_v_ff;
      out_code_in   = out_code_ff;
      out_relay_in  = out_relay_ff;
      out_secs_in   = out_secs_ff;
      out_drive_in  = out_drive_ff;
      out_last_in   = out_last_ff;

      if (push_out) begin
         out_v_in     = 1'b1;
         out_code_in  = pend_code_ff;
         out_relay_in = pend_relay_ff;
         out_secs_in  = ms_to_secs(pend_ms_ff);
         out_drive_in = pend_drive_ff;
         out_last_in  = pend_last_ff || (in_fire && !rec.has_rec);
         pend_v_in    = 1'b0;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end

      if (in_fire && rec.has_rec) begin
         pend_v_in     = 1'b1;
         pend_last_in  = rec.tick_end;
         pend_code_in  = rec.code;
         pend_relay_in = rec.relay;
         pend_ms_in    = rec.ms;
         pend_drive_in = rec.drive;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      pend_last_ff  <= pend_last_in;
      pend_code_ff  <= pend_code_in;
      pend_relay_ff <= pend_relay_in;
      pend_ms_ff    <= pend_ms_in;
      pend_drive_ff <= pend_drive_in;
      out_code_ff   <= out_code_in;
      out_relay_ff  <= out_relay_in;
      out_secs_ff   <= out_secs_in;
      out_drive_ff  <= out_drive_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid         = out_v_ff;
   assign rsp_chan.event_code    = out_code_ff;
   assign rsp_chan.relay_index   = out_relay_ff;
   assign rsp_chan.seconds_value = out_secs_ff;
   assign rsp_chan.relay_drive   = out_drive_ff;
   assign rsp_chan.last_of_tick  = out_last_ff;

endmodule

// File: hdl/paid_relay_session_timer.sv
// ----------------------------------------------------------------------------
// Paid relay session timer
// One transaction on req_chan is one millisecond tick: eight active-low
// button levels and an optional payment. Each tick yields zero to eleven
// event records on rsp_chan, in the order payment, buttons 0 to 7, timer;
// last_of_tick marks the final record of a tick.
// Eight debounce lanes judge all buttons in the cycle the tick is accepted;
// the session sequencer then advances the timers in its idle state and
// walks the payment, buttons and timer, one event per cycle while records
// are taken. The first record of a tick passes from the sequencer through
// the held-record register and the output register to rsp_chan; the rest
// follow one per cycle unless rsp_chan stalls. A one-tick input buffer
// lets the next tick be accepted while the current one is in the sequencer.
// When rsp_chan stalls, the output register and one held record fill, the
// sequencer stops and req_chan.ready drops once the input buffer is full.
// Synchronous reset restores the register defaults and clears all session
// and debounce state. csr_we writes csr_wdata to register csr_index;
// the user must write only while no tick is in flight; the block does not check.
// ----------------------------------------------------------------------------
`include "paid_relay_session_timer_defines.svh"

module paid_relay_session_timer (
   input  logic                                clock,
   input  logic                                reset,
   prst_req_if.sink                            req_chan,
   prst_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [prst_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [prst_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import prst_pkg::*;

   prst_cfg_type         cfg_ff, cfg_in;
   logic                 job_v_ff, job_v_in;
   prst_job_type         job_ff, job_in;
   logic [NUM_LANES-1:0] lane_hit;
   logic                 req_fire;
   logic                 core_ready;
   logic                 job_take;
   prst_rec_type         rec;
   logic                 rec_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (prst_csr_type'(csr_index))
            CSR_BASE_TIME:     cfg_in.base_time     = csr_wdata;
            CSR_EXTRA_TIME:    cfg_in.extra_time    = csr_wdata[11:0];
            CSR_DEBOUNCE_GAP:  cfg_in.debounce_gap  = csr_wdata[GAP_W-1:0];
            CSR_PAUSE_LOCKOUT: cfg_in.pause_lockout = csr_wdata[11:0];
            CSR_RESUME_WAIT:   cfg_in.resume_wait   = csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   assign job_take       = job_v_ff && core_ready;
   assign req_chan.ready = !job_v_ff || job_take;
   assign req_fire       = req_chan.valid && req_chan.ready;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      prst_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .tick    (req_fire),
         .pressed (~req_chan.button_levels[i]),
         .gap     (cfg_ff.debounce_gap),
         .hit     (lane_hit[i])
      );
   end

   always_comb begin
      job_in   = job_ff;
      job_v_in = job_v_ff;
      if (req_fire) begin
         job_v_in                  = 1'b1;
         job_in.pay_valid          = req_chan.pay_valid;
         job_in.pay_has_extra      = req_chan.pay_has_extra;
         job_in.pay_extra_impulses = req_chan.pay_extra_impulses;
         job_in.hits               = lane_hit;
      end else if (job_take) begin
         job_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_time     <= BASE_TIME_RST;
         cfg_ff.extra_time    <= EXTRA_TIME_RST;
         cfg_ff.debounce_gap  <= DEBOUNCE_GAP_RST;
         cfg_ff.pause_lockout <= PAUSE_LOCKOUT_RST;
         cfg_ff.resume_wait   <= RESUME_WAIT_RST;
         job_v_ff             <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         job_v_ff <= job_v_in;
      end
      job_ff <= job_in;
   end

   prst_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_v_ff),
      .job       (job_ff),
      .job_ready (core_ready),
      .rec       (rec),
      .rec_ready (rec_ready)
   );

   prst_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .rec       (rec),
      .rec_ready (rec_ready),
      .rsp_chan  (rsp_chan)
   );

   // A buffered tick stays put until the sequencer takes it.
   `PRST_ASSERT(a_job_held, job_v_ff && !job_take |=> job_v_ff, "buffered tick lost")
   // At most one relay is ever driven.
   `PRST_ASSERT(a_drive_onehot, rsp_chan.valid |-> $onehot0(rsp_chan.relay_drive), "several relays driven")
   // A stopped session leaves every relay off.
   `PRST_ASSERT(a_stop_off, rsp_chan.valid && (rsp_chan.event_code == EV_STOPPED) |-> (rsp_chan.relay_drive == 8'd0), "relay on after stop")
   // Right after reset no record is shown and a tick can be taken.
   `PRST_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> (!rsp_chan.valid && req_chan.ready), "not idle after reset")

endmodule
